// ===== hw/rtl/u8ed_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 and entity decoder.
package u8ed_pkg;

    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);
    localparam int NUM_ENT    = 6;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_CHAR    = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_BADLEAD = 2'd2,
        ST_TRUNC   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_UTF8 = 2'd1,
        MODE_NAME = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  rem;
        logic [15:0] val;
        logic [2:0]  pos;
        logic [5:0]  cand;
    } dec_state_t;

    // Results of one step toward the result queue.
    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  r0;
        out_item_t  r1;
    } push_t;

    typedef struct packed {
        dec_state_t  st;
        logic        emit;
        logic [15:0] code;
        status_t     status;
    } fresh_t;

    localparam dec_state_t IDLE_ST = '{
        mode: MODE_IDLE, rem: 2'd0, val: 16'd0, pos: 3'd0, cand: 6'h3f
    };

    localparam logic [7:0] AMP = 8'h26;

    // Entity names, "&#x", "&amp;", "&quot;", "&lt;", "&gt;", "&nbsp;".
    localparam logic [7:0] ENT_TEXT [0:7][0:7] = '{
        '{8'h26, 8'h23, 8'h78, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00, 8'h00, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] ENT_LEN [0:7] = '{
        3'd3, 3'd5, 3'd6, 3'd4, 3'd4, 3'd6, 3'd0, 3'd0
    };
    localparam logic [15:0] ENT_VALUE [0:7] = '{
        16'h0000, 16'h0026, 16'h0022, 16'h003c, 16'h003e, 16'h00a0, 16'h0000, 16'h0000
    };

    // Handle a byte as the start of a new character.
    function automatic fresh_t fresh_byte(input logic [7:0] b);
        fresh_t f;
        f.st     = IDLE_ST;
        f.emit   = 1'b0;
        f.code   = 16'd0;
        f.status = ST_CHAR;
        priority if (b == AMP) begin
            f.st.mode = MODE_NAME;
            f.st.pos  = 3'd1;
        end else if (!b[7]) begin
            f.emit = 1'b1;
            f.code = {8'd0, b};
        end else if (b[7:5] == 3'b110) begin
            f.st.mode = MODE_UTF8;
            f.st.rem  = 2'd1;
            f.st.val  = {11'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            f.st.mode = MODE_UTF8;
            f.st.rem  = 2'd2;
            f.st.val  = {12'd0, b[3:0]};
        end else begin
            f.emit   = 1'b1;
            f.status = ST_BADLEAD;
        end
        return f;
    endfunction

    // {hit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        priority if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/u8ed_core.sv =====
// Input register, decode state and single-pass decode logic.
module u8ed_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u8ed_pkg::in_item_t  s_item,
    input  logic                room,
    output u8ed_pkg::push_t     push
);

    logic                 in_vld_reg;
    u8ed_pkg::in_item_t   in_item_reg;
    u8ed_pkg::dec_state_t st_reg;
    u8ed_pkg::dec_state_t st_next;
    logic                 step;
    logic [7:0]           b;
    logic [2:0]           p;
    logic [5:0]           keep;
    logic                 done_any;
    logic [2:0]           done_idx;
    u8ed_pkg::fresh_t     fr;
    logic [4:0]           hd;
    logic                 e0;
    logic [15:0]          c0;
    u8ed_pkg::status_t    s0;
    logic                 use_f;
    logic [1:0]           rem_dec;
    logic [15:0]          utf_val;

    assign step    = in_vld_reg && room;
    assign s_ready = !in_vld_reg || step;
    assign b       = in_item_reg.data_byte;
    assign p       = st_reg.pos;
    assign fr      = u8ed_pkg::fresh_byte(b);
    assign hd      = u8ed_pkg::hex_digit(b);
    assign rem_dec = st_reg.rem - 2'd1;
    assign utf_val = {st_reg.val[9:0], b[5:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            st_reg     <= u8ed_pkg::IDLE_ST;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_comb begin
        keep     = 6'd0;
        done_any = 1'b0;
        done_idx = 3'd0;
        for (int i = 0; i < u8ed_pkg::NUM_ENT; i++) begin
            keep[i] = st_reg.cand[i] && (p < u8ed_pkg::ENT_LEN[i])
                      && (u8ed_pkg::ENT_TEXT[i][p] == b);
        end
        for (int i = u8ed_pkg::NUM_ENT - 1; i >= 0; i--) begin
            if (keep[i] && (3'(p + 3'd1) == u8ed_pkg::ENT_LEN[i])) begin
                done_any = 1'b1;
                done_idx = 3'(i);
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        e0      = 1'b0;
        c0      = 16'd0;
        s0      = u8ed_pkg::ST_CHAR;
        use_f   = 1'b0;
        if (in_item_reg.operation == u8ed_pkg::OP_END) begin
            st_next = u8ed_pkg::IDLE_ST;
            if (st_reg.mode == u8ed_pkg::MODE_HEX) begin
                e0 = 1'b1;
                c0 = st_reg.val;
            end else if (st_reg.mode != u8ed_pkg::MODE_IDLE) begin
                e0 = 1'b1;
                s0 = u8ed_pkg::ST_TRUNC;
            end
        end else begin
            unique case (st_reg.mode)
                u8ed_pkg::MODE_UTF8: begin
                    if (rem_dec == 2'd0) begin
                        e0      = 1'b1;
                        c0      = utf_val;
                        st_next = u8ed_pkg::IDLE_ST;
                    end else begin
                        st_next.val = utf_val;
                        st_next.rem = rem_dec;
                    end
                end
                u8ed_pkg::MODE_HEX: begin
                    if (hd[4]) begin
                        st_next.val = {st_reg.val[11:0], hd[3:0]};
                    end else begin
                        e0      = 1'b1;
                        c0      = st_reg.val;
                        use_f   = 1'b1;
                        st_next = fr.st;
                    end
                end
                u8ed_pkg::MODE_NAME: begin
                    if (keep == 6'd0) begin
                        e0      = 1'b1;
                        s0      = u8ed_pkg::ST_UNKNOWN;
                        use_f   = 1'b1;
                        st_next = fr.st;
                    end else if (done_any && done_idx == 3'd0) begin
                        st_next      = u8ed_pkg::IDLE_ST;
                        st_next.mode = u8ed_pkg::MODE_HEX;
                    end else if (done_any) begin
                        e0      = 1'b1;
                        c0      = u8ed_pkg::ENT_VALUE[done_idx];
                        st_next = u8ed_pkg::IDLE_ST;
                    end else begin
                        st_next.cand = keep;
                        st_next.pos  = 3'(p + 3'd1);
                    end
                end
                u8ed_pkg::MODE_IDLE: begin
                    use_f   = 1'b1;
                    st_next = fr.st;
                end
                default: begin
                    st_next = u8ed_pkg::IDLE_ST;
                end
            endcase
        end
        if (!step) begin
            st_next = st_reg;
        end
    end

    always_comb begin
        push.cnt = 2'd0;
        push.r0  = '{code_unit: c0, status: s0, last_of_run: 1'b1};
        push.r1  = '{code_unit: fr.code, status: fr.status, last_of_run: 1'b1};
        if (step) begin
            if (e0 && use_f && fr.emit) begin
                push.cnt            = 2'd2;
                push.r0.last_of_run = 1'b0;
            end else if (e0) begin
                push.cnt = 2'd1;
            end else if (use_f && fr.emit) begin
                push.cnt = 2'd1;
                push.r0  = push.r1;
            end
        end
    end

endmodule

// ===== hw/rtl/u8ed_resq.sv =====
// Result queue: takes up to two items per cycle, hands out one.
module u8ed_resq (
    input  logic                aclk,
    input  logic                aresetn,
    input  u8ed_pkg::push_t     push,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output u8ed_pkg::out_item_t m_item
);

    localparam int PW = u8ed_pkg::RESQ_PTR_W;
    localparam int CW = u8ed_pkg::RESQ_CNT_W;

    u8ed_pkg::out_item_t mem [u8ed_pkg::RESQ_DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                pop;

    assign m_valid  = cnt_reg != '0;
    assign pop      = m_valid && m_ready;
    assign m_item   = mem[rd_ptr_reg];
    assign room     = (CW'(u8ed_pkg::RESQ_DEPTH) - cnt_reg) >= CW'(2);
    assign cnt_next = cnt_reg + CW'(push.cnt) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push.cnt);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem[PW'(wr_ptr_reg + PW'(1))] <= push.r1;
        end
    end

endmodule

// ===== hw/rtl/utf8_and_entity_decoder_unit.sv =====
// Top level of the UTF-8 and entity decoder.
// Takes one text byte (or an end-of-text marker) per item and produces 16-bit
// code units: one- to three-byte UTF-8, "&#x" hex entities and the named
// entities amp, quot, lt, gt and nbsp, with error statuses for bad lead bytes,
// unknown entities and truncated sequences. An item may give zero, one or two
// results; last_of_run marks the final result of each item. Input items are
// accepted one per cycle; the decode is combinational between the input
// register and a four-entry result queue, and the input stalls only while the
// queue has fewer than two free entries. A result passes through the input
// register and then the result queue before it reaches the output.
module utf8_and_entity_decoder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u8ed_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output u8ed_pkg::out_item_t m_item
);

    u8ed_pkg::push_t push;
    logic            room;

    u8ed_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .room    (room),
        .push    (push)
    );

    u8ed_resq u_resq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
